FILE: rtl/core/vss_pkg.sv
`default_nettype none

package vss_pkg;

  // default sizes of the voice table and of the voice fields
  localparam int MAX_VOICES_DEF  = 64;
  localparam int AGE_BITS_DEF    = 32;
  localparam int REGION_BITS_DEF = 12;

  // trigger channel width, fixed by the event format
  localparam int CHAN_W = 4;

  // encoding of the stealer mode register, which resets to oldest
  typedef enum logic {
    MODE_FIRST  = 1'b0,
    MODE_OLDEST = 1'b1
  } steal_mode_t;

endpackage

`default_nettype wire

FILE: rtl/core/voice_steal_scan_top.sv
`default_nettype none

// a result passes the slot register and the result register before it leaves on out_tdata
// throughput: one voice slot per cycle unless a last slot waits on the result register;
//   accumulate path: two age compares and one count increment, slot register to scan state
// reset (rst_n low, synchronous): stealer mode goes to oldest, the scan state is cleared
//   and both the slot register and the result register are emptied
module voice_steal_scan_top #(
  parameter int MAX_VOICES  = vss_pkg::MAX_VOICES_DEF,
  parameter int AGE_BITS    = vss_pkg::AGE_BITS_DEF,
  parameter int REGION_BITS = vss_pkg::REGION_BITS_DEF,
  // derived sizes, not meant to be overridden
  parameter int IDX_W  = $clog2(MAX_VOICES),
  parameter int CNT_W  = $clog2(MAX_VOICES + 1),
  parameter int IN_W   = IDX_W + 1 + REGION_BITS + AGE_BITS + vss_pkg::CHAN_W + 1
                         + REGION_BITS + CNT_W + 1 + vss_pkg::CHAN_W,
  parameter int IN_TW  = ((IN_W + 7) / 8) * 8,
  parameter int OUT_W  = 1 + IDX_W + CNT_W,
  parameter int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration: stealer_mode
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  // slot stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // low bit up: voice_index, voice_active, voice_region, voice_age, voice_channel,
  // region_only, target_region, polyphony_limit, prefer_channel, preferred_channel, zero pad
  input  wire logic [IN_TW-1:0]  in_tdata,
  input  wire logic              in_tlast,   // last_voice
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // low bit up: steal_found, steal_index, active_count, zero pad
  output logic [OUT_TW-1:0]      out_tdata
);
  import vss_pkg::*;

  // field offsets inside in_tdata
  localparam int O_IDX    = 0;
  localparam int O_ACT    = O_IDX + IDX_W;
  localparam int O_REG    = O_ACT + 1;
  localparam int O_AGE    = O_REG + REGION_BITS;
  localparam int O_CHAN   = O_AGE + AGE_BITS;
  localparam int O_RONLY  = O_CHAN + CHAN_W;
  localparam int O_TGT    = O_RONLY + 1;
  localparam int O_LIM    = O_TGT + REGION_BITS;
  localparam int O_PREF   = O_LIM + CNT_W;
  localparam int O_PCHAN  = O_PREF + 1;

  // ---------------------------------------------------------------------------
  // stealer mode register
  // ---------------------------------------------------------------------------
  steal_mode_t mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OLDEST;
    end else if (cfg_we) begin
      mode_r <= steal_mode_t'(cfg_wdata);
    end
  end

  // ---------------------------------------------------------------------------
  // slot register: holds one transferred slot for the scan step
  // ---------------------------------------------------------------------------
  logic             slot_vld_r;
  logic [IN_W-1:0]  slot_r;
  logic             slot_last_r;

  logic             out_free;
  logic             slot_adv;

  // a slot that emits a result waits until the result register has room
  assign out_free  = !out_tvalid || out_tready;
  assign slot_adv  = slot_vld_r && (!slot_last_r || out_free);
  assign in_tready = !slot_vld_r || slot_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= 1'b0;
    end else if (in_tready) begin
      slot_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      slot_r      <= in_tdata[IN_W-1:0];
      slot_last_r <= in_tlast;
    end
  end

  // slot fields
  logic [IDX_W-1:0]       s_idx;
  logic                   s_act;
  logic [REGION_BITS-1:0] s_region;
  logic [AGE_BITS-1:0]    s_age;
  logic [CHAN_W-1:0]      s_chan;
  logic                   s_ronly;
  logic [REGION_BITS-1:0] s_target;
  logic [CNT_W-1:0]       s_limit;
  logic                   s_pref;
  logic [CHAN_W-1:0]      s_pchan;

  assign s_idx    = slot_r[O_IDX   +: IDX_W];
  assign s_act    = slot_r[O_ACT];
  assign s_region = slot_r[O_REG   +: REGION_BITS];
  assign s_age    = slot_r[O_AGE   +: AGE_BITS];
  assign s_chan   = slot_r[O_CHAN  +: CHAN_W];
  assign s_ronly  = slot_r[O_RONLY];
  assign s_target = slot_r[O_TGT   +: REGION_BITS];
  assign s_limit  = slot_r[O_LIM   +: CNT_W];
  assign s_pref   = slot_r[O_PREF];
  assign s_pchan  = slot_r[O_PCHAN +: CHAN_W];

  // ---------------------------------------------------------------------------
  // scan state
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]    best_slot_r, best_slot_nxt;
  logic [AGE_BITS-1:0] best_age_r,  best_age_nxt;
  logic                have_best_r, have_best_nxt;
  logic [IDX_W-1:0]    sc_slot_r,   sc_slot_nxt;
  logic [AGE_BITS-1:0] sc_age_r,    sc_age_nxt;
  logic                have_sc_r,   have_sc_nxt;
  logic [CNT_W-1:0]    qcnt_r,      qcnt_nxt;

  logic qualifies;
  logic best_take;
  logic sc_take;

  // voice counts when live and it passes the region filter
  assign qualifies = s_act && (!s_ronly || (s_region == s_target));

  // first mode keeps the first candidate, oldest mode takes a strictly older one
  assign best_take = !have_best_r || ((mode_r == MODE_OLDEST) && (s_age > best_age_r));
  assign sc_take   = !have_sc_r   || ((mode_r == MODE_OLDEST) && (s_age > sc_age_r));

  // state after this slot is scanned, before the end-of-scan clear
  always_comb begin
    best_slot_nxt = best_slot_r;
    best_age_nxt  = best_age_r;
    have_best_nxt = have_best_r;
    sc_slot_nxt   = sc_slot_r;
    sc_age_nxt    = sc_age_r;
    have_sc_nxt   = have_sc_r;
    qcnt_nxt      = qcnt_r;
    if (qualifies) begin
      if (best_take) begin
        best_slot_nxt = s_idx;
        best_age_nxt  = s_age;
        have_best_nxt = 1'b1;
      end
      if (s_pref && (s_chan == s_pchan) && sc_take) begin
        sc_slot_nxt = s_idx;
        sc_age_nxt  = s_age;
        have_sc_nxt = 1'b1;
      end
      // count saturates at the voice table size
      if (qcnt_r < CNT_W'(MAX_VOICES)) begin
        qcnt_nxt = qcnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_slot_r <= '0;
      best_age_r  <= '0;
      have_best_r <= 1'b0;
      sc_slot_r   <= '0;
      sc_age_r    <= '0;
      have_sc_r   <= 1'b0;
      qcnt_r      <= '0;
    end else if (slot_adv) begin
      if (slot_last_r) begin
        // end of scan: start the next one empty
        best_slot_r <= '0;
        best_age_r  <= '0;
        have_best_r <= 1'b0;
        sc_slot_r   <= '0;
        sc_age_r    <= '0;
        have_sc_r   <= 1'b0;
        qcnt_r      <= '0;
      end else begin
        best_slot_r <= best_slot_nxt;
        best_age_r  <= best_age_nxt;
        have_best_r <= have_best_nxt;
        sc_slot_r   <= sc_slot_nxt;
        sc_age_r    <= sc_age_nxt;
        have_sc_r   <= have_sc_nxt;
        qcnt_r      <= qcnt_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // verdict on the last slot; same-channel candidate wins over the general one
  // ---------------------------------------------------------------------------
  logic             found;
  logic [IDX_W-1:0] victim;

  always_comb begin
    found  = 1'b0;
    victim = '0;
    if (qcnt_nxt >= s_limit) begin
      if (have_sc_nxt) begin
        found  = 1'b1;
        victim = sc_slot_nxt;
      end else if (have_best_nxt) begin
        found  = 1'b1;
        victim = best_slot_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic              out_vld_r;
  logic [OUT_W-1:0]  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= slot_adv && slot_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && slot_adv && slot_last_r) begin
      out_data_r <= {qcnt_nxt, victim, found};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TW'(out_data_r);

endmodule

`default_nettype wire

FILE: tb/sv/voice_steal_scan_checker.sv
`default_nettype none

// watches the slot and result streams, predicts each scan verdict and compares
module voice_steal_scan_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [79:0] in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,
  output int               mismatches,
  output int               pending
);
  import vss_pkg::*;

  // slot transfer layout, msb first
  typedef struct packed {
    logic [3:0]  preferred_channel;
    logic        prefer_channel;
    logic [6:0]  polyphony_limit;
    logic [11:0] target_region;
    logic        region_only;
    logic [3:0]  voice_channel;
    logic [31:0] voice_age;
    logic [11:0] voice_region;
    logic        voice_active;
    logic [5:0]  voice_index;
  } slot_t;

  // result transfer layout, msb first, without the pad
  typedef struct packed {
    logic [6:0] count;
    logic [5:0] slot;
    logic       found;
  } verdict_t;

  steal_mode_t mode;
  logic [5:0]  cand_slot;
  logic [31:0] cand_age;
  logic        have_cand;
  logic [5:0]  chan_slot;
  logic [31:0] chan_age;
  logic        have_chan;
  logic [6:0]  voice_count;

  // expected verdicts in arrival order, ring of 16 entries
  verdict_t    verdict_fifo [16];
  logic [3:0]  vf_wr;
  logic [3:0]  vf_rd;
  int          vf_fill;

  function automatic logic takes_lead(logic have, logic [31:0] held, logic [31:0] age);
    return !have || (mode == MODE_OLDEST && age > held);
  endfunction

  task automatic clear_scan();
    cand_slot   = '0;
    cand_age    = '0;
    have_cand   = 1'b0;
    chan_slot   = '0;
    chan_age    = '0;
    have_chan   = 1'b0;
    voice_count = '0;
  endtask

  task automatic scan_slot(input slot_t s, input logic last);
    verdict_t v;
    if (s.voice_active && (!s.region_only || s.voice_region == s.target_region)) begin
      if (takes_lead(have_cand, cand_age, s.voice_age)) begin
        cand_slot = s.voice_index;
        cand_age  = s.voice_age;
        have_cand = 1'b1;
      end
      if (s.prefer_channel && s.voice_channel == s.preferred_channel &&
          takes_lead(have_chan, chan_age, s.voice_age)) begin
        chan_slot = s.voice_index;
        chan_age  = s.voice_age;
        have_chan = 1'b1;
      end
      // count saturates at the table size
      if (voice_count < 7'(MAX_VOICES_DEF)) voice_count = voice_count + 7'd1;
    end
    if (last) begin
      v = '0;
      if (voice_count >= s.polyphony_limit) begin
        if (have_chan) begin
          v.found = 1'b1;
          v.slot  = chan_slot;
        end else if (have_cand) begin
          v.found = 1'b1;
          v.slot  = cand_slot;
        end
      end
      v.count = voice_count;
      if (vf_fill >= 16) begin
        $display("%0t: too many results outstanding, expected at most 16, actual %0d",
                 $time, vf_fill + 1);
        mismatches++;
      end else begin
        verdict_fifo[vf_wr] = v;
        vf_wr   = vf_wr + 4'd1;
        vf_fill = vf_fill + 1;
      end
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      mode = MODE_OLDEST;
      clear_scan();
      vf_wr      = '0;
      vf_rd      = '0;
      vf_fill    = 0;
      mismatches = 0;
    end else begin
      if (cfg_we) mode = steal_mode_t'(cfg_wdata);
      if (in_tvalid && in_tready) scan_slot(slot_t'(in_tdata), in_tlast);
      if (out_tvalid && out_tready) begin
        if (vf_fill == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          v       = verdict_fifo[vf_rd];
          vf_rd   = vf_rd + 4'd1;
          vf_fill = vf_fill - 1;
          if (out_tdata !== {2'b00, v}) begin
            $display("%0t: steal result mismatch, expected found=%0d slot=%0d count=%0d, %s",
                     $time, v.found, v.slot, v.count, "actual below");
            $display("%0t:   actual found=%0d slot=%0d count=%0d pad=%0d", $time,
                     out_tdata[0], out_tdata[6:1], out_tdata[13:7], out_tdata[15:14]);
            mismatches++;
          end
        end
      end
    end
    pending = vf_fill;
  end

endmodule

`default_nettype wire

FILE: tb/sv/voice_steal_scan_top_tb.sv
`default_nettype none

module voice_steal_scan_top_tb;
  import vss_pkg::*;

  // no transfer for this many cycles means the block is stuck
  localparam int WATCHDOG_CYCLES = 1000;
  // extra idle time after the last result is back, kept as margin
  localparam int DRAIN_CYCLES    = 4;
  localparam int RANDOM_ITEMS    = 1400;
  // mode register gets rewritten after roughly this many random slots
  localparam int PHASE_ITEMS     = 200;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // low bit up: voice_index, voice_active, voice_region, voice_age, voice_channel,
  // region_only, target_region, polyphony_limit, prefer_channel, preferred_channel
  logic [79:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;   // last_voice
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // low bit up: steal_found, steal_index, active_count, zero pad
  logic [15:0] out_tdata;

  int mismatches;
  int pending;
  int idle_cycles = 0;
  int items_sent  = 0;
  // set per scan: both sides run without gaps
  bit calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  voice_steal_scan_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  voice_steal_scan_checker steal_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // watchdog: counts cycles with no transfer on either stream
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result sink: random stall before each result, ready stays up until a transfer
  initial begin : result_sink
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  // one slot transfer; called and returns at a falling edge
  task automatic send_slot(input logic [5:0] idx, input logic act, input logic [11:0] rgn,
                           input logic [31:0] age, input logic [3:0] chan, input logic ro,
                           input logic [11:0] tgt, input logic [6:0] lim, input logic pref,
                           input logic [3:0] pch, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {pch, pref, lim, tgt, ro, chan, age, rgn, act, idx};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // stop sending until every expected verdict is back and the pipe has drained
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // the mode register is only touched with the block idle
  task automatic write_mode(input steal_mode_t m);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one random scan: mostly a well-formed scan with fixed filter settings and
  // ascending slots; some scans jitter the filter fields per slot, a few are
  // long and dense enough to saturate the voice count
  task automatic random_scan();
    int          len;
    int          i;
    int          lim_top;
    bit          dense;
    bit          jitter;
    logic        ro;
    logic        pref;
    logic [11:0] tgt;
    logic [3:0]  pch;
    logic [5:0]  idx;
    logic        act;
    logic [11:0] rgn;
    logic [31:0] age;
    logic [31:0] prev_age;
    logic [3:0]  chan;
    logic [6:0]  lim;
    dense    = ($urandom_range(0, 24) == 0);
    len      = dense ? $urandom_range(60, 72) : $urandom_range(1, 16);
    jitter   = !dense && ($urandom_range(0, 7) == 0);
    calm     = ($urandom_range(0, 4) == 0);
    ro       = dense ? 1'b0 : 1'($urandom_range(0, 1));
    tgt      = 12'($urandom);
    pref     = ($urandom_range(0, 3) != 0);
    pch      = 4'($urandom);
    idx      = 6'($urandom);
    prev_age = $urandom;
    lim_top  = (len + 2 > 64) ? 64 : len + 2;
    for (i = 0; i < len; i++) begin
      if (jitter) begin
        ro   = 1'($urandom_range(0, 1));
        tgt  = ($urandom_range(0, 1) != 0) ? tgt : 12'($urandom);
        pref = 1'($urandom_range(0, 1));
        pch  = ($urandom_range(0, 1) != 0) ? pch : 4'($urandom);
      end
      act = dense || ($urandom_range(0, 4) != 0);
      // regions near the target so the filter both passes and rejects
      case ($urandom_range(0, 3))
        0, 1:    rgn = tgt;
        2:       rgn = tgt ^ (12'h1 << $urandom_range(0, 11));
        default: rgn = 12'($urandom);
      endcase
      chan = ($urandom_range(0, 1) != 0) ? pch : 4'($urandom);
      // extremes and ties matter for the oldest rule
      case ($urandom_range(0, 7))
        0:       age = '0;
        1:       age = '1;
        2:       age = prev_age;
        3:       age = $urandom_range(0, 15);
        default: age = $urandom;
      endcase
      prev_age = age;
      // limit only counts on the last slot
      if (i == len - 1) begin
        lim = (dense || $urandom_range(0, 9) == 0) ? 7'd64 : 7'($urandom_range(0, lim_top));
      end else begin
        lim = 7'($urandom_range(0, 64));
      end
      send_slot(idx, act, rgn, age, chan, ro, tgt, lim, pref, pch, i == len - 1);
      idx = jitter ? 6'($urandom) : idx + 6'd1;
    end
  endtask

  initial begin : stimulus
    int          random_start;
    int          phase_start;
    int          phase;
    steal_mode_t m;
    // single reset pulse
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed scans, mode still at its reset value (oldest)
    calm = 1'b1;
    // lone inactive last slot with a zero limit: nothing counted, no steal
    send_slot(6'd5, 1'b0, 12'h000, 32'h0, 4'h0, 1'b0, 12'h000, 7'd0, 1'b0, 4'h0, 1'b1);
    // oldest wins, tie on the max age keeps the earlier slot
    send_slot(6'd3,  1'b1, 12'h001, 32'h5,        4'h1, 1'b0, 12'h000, 7'd0, 1'b0, 4'h0, 1'b0);
    send_slot(6'd7,  1'b1, 12'h002, 32'hffffffff, 4'h2, 1'b0, 12'h000, 7'd0, 1'b0, 4'h0, 1'b0);
    send_slot(6'd9,  1'b1, 12'h003, 32'hffffffff, 4'h3, 1'b0, 12'h000, 7'd0, 1'b0, 4'h0, 1'b0);
    send_slot(6'd12, 1'b1, 12'h004, 32'h0,        4'h4, 1'b0, 12'h000, 7'd4, 1'b0, 4'h0, 1'b1);
    calm = 1'b0;
    // region filter plus channel preference, last slot inactive
    send_slot(6'd63, 1'b1, 12'hfff, 32'h1,        4'hf, 1'b1, 12'hfff, 7'd0, 1'b1, 4'hf, 1'b0);
    send_slot(6'd0,  1'b1, 12'hfff, 32'd100,      4'h0, 1'b1, 12'hfff, 7'd0, 1'b1, 4'hf, 1'b0);
    send_slot(6'd20, 1'b1, 12'h000, 32'd200,      4'hf, 1'b1, 12'hfff, 7'd0, 1'b1, 4'hf, 1'b0);
    send_slot(6'd21, 1'b0, 12'hfff, 32'hffffffff, 4'hf, 1'b1, 12'hfff, 7'd2, 1'b1, 4'hf, 1'b1);

    write_mode(MODE_FIRST);
    // first qualifying voice wins whatever the ages
    send_slot(6'd10, 1'b1, 12'h123, 32'h1,        4'h7, 1'b0, 12'h000, 7'd0, 1'b0, 4'h0, 1'b0);
    send_slot(6'd11, 1'b1, 12'h124, 32'hffffffff, 4'h7, 1'b0, 12'h000, 7'd0, 1'b0, 4'h0, 1'b0);
    send_slot(6'd12, 1'b1, 12'h125, 32'h7,        4'h7, 1'b0, 12'h000, 7'd3, 1'b0, 4'h0, 1'b1);
    // limit at the table size is out of reach for a short scan
    send_slot(6'd1, 1'b1, 12'h000, 32'h9, 4'h2, 1'b0, 12'h000, 7'd0,  1'b1, 4'h5, 1'b0);
    send_slot(6'd2, 1'b1, 12'h000, 32'h8, 4'h5, 1'b0, 12'h000, 7'd0,  1'b1, 4'h5, 1'b0);
    send_slot(6'd3, 1'b1, 12'h000, 32'h7, 4'h5, 1'b0, 12'h000, 7'd64, 1'b1, 4'h5, 1'b1);
    // region filter rejects the only voice
    send_slot(6'd0, 1'b1, 12'h001, 32'h3, 4'h0, 1'b1, 12'h002, 7'd1,  1'b0, 4'h0, 1'b1);

    write_mode(MODE_OLDEST);

    // random scans, phases alternate the stealer mode
    random_start = items_sent;
    phase_start  = items_sent;
    phase        = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      random_scan();
      if (items_sent - phase_start >= PHASE_ITEMS) begin
        phase++;
        m = (phase % 2 != 0) ? MODE_FIRST : MODE_OLDEST;
        write_mode(m);
        phase_start = items_sent;
      end else if ($urandom_range(0, 19) == 0) begin
        // hold the sender until the result stream is empty
        wait_idle();
      end
    end

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
